// ----- sv/suffix_array_lcp_builder_assert.svh -----
// Assertion macros for the suffix array builder.
// Used by the top level; no other dependencies.
`ifndef SUFFIX_ARRAY_LCP_BUILDER_ASSERT_SVH
`define SUFFIX_ARRAY_LCP_BUILDER_ASSERT_SVH
`ifndef ASSERT_OFF
`define SA_ASSERT_IMP(label, clk, rst_n, a, c, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
`define SA_ASSERT_NXT(label, clk, rst_n, a, c, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`else
`define SA_ASSERT_IMP(label, clk, rst_n, a, c, msg)
`define SA_ASSERT_NXT(label, clk, rst_n, a, c, msg)
`endif
`endif

// ----- sv/salcp_pkg.sv -----
// Shared types and constants for the suffix array builder.
// No dependencies.
package salcp_pkg;
	localparam int MAX_LEN_DEF = 4096;
	localparam int IDX_W = 12;
	localparam logic OP_APPEND = 1'b0;
	localparam logic OP_READ   = 1'b1;
	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_BAD_INDEX = 2'd1;
	localparam logic [1:0] ST_OVERFLOW = 2'd2;

	typedef struct packed {
		logic        operation;
		logic [7:0]  char_value;
		logic        end_of_text;
		logic [11:0] rank_index;
	} in_item_t;

	typedef struct packed {
		logic [11:0] suffix_start;
		logic [11:0] lcp_with_next;
		logic [1:0]  status;
	} out_item_t;
endpackage

// ----- sv/salcp_ram.sv -----
// Generic single-port-write, one-read RAM with registered read data.
// No dependencies.
module salcp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ----- sv/suffix_array_lcp_builder.sv -----
// Suffix array and LCP builder: an append is taken while idle; a read steps through S_RDWAIT
// and S_RD2, which register its beat, and the input stalls until the read is done.
// The build after the last byte walks block RAMs, one access per RAM per cycle: it ranks
// bytes by a symbol bucket sort, runs ceil(log2 m) prefix doubling rounds, then a Kasai
// pass that compares matched bytes one by one; m = length + 1.
// Reset clears the length, built flag and handshake; RAM contents stay undefined.
`include "suffix_array_lcp_builder_assert.svh"
module suffix_array_lcp_builder #(
	parameter int MAX_LEN = salcp_pkg::MAX_LEN_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  salcp_pkg::in_item_t  in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output salcp_pkg::out_item_t out_data
);
	localparam int LWN = $clog2(MAX_LEN + 3) + 1; // holds up to 2*(MAX_LEN+1)
	localparam int LW = (LWN > 13) ? LWN : 13;    // also holds 258 and 12-bit fields
	localparam int TAW = $clog2(MAX_LEN);
	localparam int SAW = $clog2(MAX_LEN + 2);
	localparam int BKD = (MAX_LEN + 2 > 258) ? MAX_LEN + 2 : 258;
	localparam int BAW = $clog2(BKD);

	typedef enum logic [17:0] {
		S_IDLE   = 18'h00001,
		S_HCLR   = 18'h00002, // clear 258 symbol buckets
		S_HCNT   = 18'h00004, // count symbols
		S_HPFX   = 18'h00008, // prefix sum symbol buckets
		S_HPLACE = 18'h00010, // place by symbol
		S_HRANK  = 18'h00020, // initial classes
		S_SHIFT  = 18'h00040, // shifted order
		S_BCLR   = 18'h00080,
		S_BCNT   = 18'h00100,
		S_BPFX   = 18'h00200,
		S_BPLACE = 18'h00400,
		S_NCLS   = 18'h00800, // new classes into shifted_order
		S_CPY    = 18'h01000, // classes back to class_rank
		S_INV    = 18'h02000, // inverse order
		S_KAS    = 18'h04000, // Kasai pass
		S_RDWAIT = 18'h08000,
		S_RD2    = 18'h10000,
		S_APP    = 18'h20000
	} state_t;

	state_t st_q;
	logic [2:0] ph_q;        // micro phase within one element
	logic [LW-1:0] len_q, m_q, h_q, i_q, r_q, a_q, b_q, x_q, v_q, w_q, kh_q, j_q, tr_q;
	logic [7:0] c_q;
	logic built_q;
	logic [LW-1:0] rd_idx_q;

	// RAM ports
	logic t_we; logic [TAW-1:0] t_wa, t_ra; logic [7:0] t_wd, t_rd;
	logic so_we; logic [SAW-1:0] so_wa, so_ra; logic [LW-1:0] so_wd, so_rd;
	logic cr_we; logic [SAW-1:0] cr_wa, cr_ra; logic [LW-1:0] cr_wd, cr_rd;
	logic sh_we; logic [SAW-1:0] sh_wa, sh_ra; logic [LW-1:0] sh_wd, sh_rd;
	logic bk_we; logic [BAW-1:0] bk_wa, bk_ra; logic [LW-1:0] bk_wd, bk_rd;
	logic lc_we; logic [TAW-1:0] lc_wa, lc_ra; logic [LW-1:0] lc_wd, lc_rd;

	salcp_ram #(.WIDTH(8), .DEPTH(MAX_LEN), .AW(TAW)) u_text (.clk, .we(t_we),
		.waddr(t_wa), .wdata(t_wd), .raddr(t_ra), .rdata(t_rd));
	salcp_ram #(.WIDTH(LW), .DEPTH(MAX_LEN + 1), .AW(SAW)) u_so (.clk, .we(so_we),
		.waddr(so_wa), .wdata(so_wd), .raddr(so_ra), .rdata(so_rd));
	salcp_ram #(.WIDTH(LW), .DEPTH(MAX_LEN + 1), .AW(SAW)) u_cr (.clk, .we(cr_we),
		.waddr(cr_wa), .wdata(cr_wd), .raddr(cr_ra), .rdata(cr_rd));
	salcp_ram #(.WIDTH(LW), .DEPTH(MAX_LEN + 1), .AW(SAW)) u_sh (.clk, .we(sh_we),
		.waddr(sh_wa), .wdata(sh_wd), .raddr(sh_ra), .rdata(sh_rd));
	salcp_ram #(.WIDTH(LW), .DEPTH(BKD), .AW(BAW)) u_bk (.clk, .we(bk_we),
		.waddr(bk_wa), .wdata(bk_wd), .raddr(bk_ra), .rdata(bk_rd));
	salcp_ram #(.WIDTH(LW), .DEPTH(MAX_LEN), .AW(TAW)) u_lc (.clk, .we(lc_we),
		.waddr(lc_wa), .wdata(lc_wd), .raddr(lc_ra), .rdata(lc_rd));

	// symbol of the text byte just read; marker (past end) is zero
	function automatic logic [LW-1:0] sym(input logic [LW-1:0] pos, input logic [LW-1:0] n,
			input logic [7:0] b);
		sym = (pos >= n) ? '0 : LW'({1'b0, b}) + LW'(1);
	endfunction

	// (p + d) mod m for p, d < m
	function automatic logic [LW-1:0] addm(input logic [LW-1:0] p, input logic [LW-1:0] d,
			input logic [LW-1:0] m);
		logic [LW-1:0] s;
		s = p + d;
		addm = (s >= m) ? s - m : s;
	endfunction

	logic in_acc, out_acc;
	logic out_full;
	assign in_stall = (st_q != S_IDLE) || (out_full && out_stall);
	assign in_acc = in_valid && !in_stall;
	assign out_acc = out_valid && !out_stall;
	assign out_valid = out_full;

	logic [LW-1:0] sa_tmp;

	// sequencer: drive RAM ports and advance
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			ph_q <= '0;
			len_q <= '0;
			built_q <= 1'b0;
			out_full <= 1'b0;
			m_q <= '0; h_q <= '0; i_q <= '0; r_q <= '0;
		end else begin
			logic full_nx;
			full_nx = out_full && !out_acc;
			unique case (st_q)
				S_IDLE: begin
					if (in_acc) begin
						if (in_data.operation == salcp_pkg::OP_APPEND) begin
							logic [LW-1:0] nl;
							nl = built_q ? '0 : len_q;
							built_q <= 1'b0;
							if (nl < LW'(MAX_LEN)) begin
								len_q <= nl + LW'(1);
								nl = nl + LW'(1);
							end else begin
								len_q <= nl;
								full_nx = 1'b1;
								out_data <= '{12'd0, 12'd0, salcp_pkg::ST_OVERFLOW};
							end
							if (in_data.end_of_text) begin
								m_q <= nl + LW'(1);
								i_q <= '0;
								ph_q <= '0;
								st_q <= S_HCLR;
							end
						end else begin
							if (!built_q || LW'(in_data.rank_index) >= len_q) begin
								full_nx = 1'b1;
								out_data <= '{12'd0, 12'd0, salcp_pkg::ST_BAD_INDEX};
							end else begin
								rd_idx_q <= LW'(in_data.rank_index);
								st_q <= S_RDWAIT;
							end
						end
					end
				end
				S_RDWAIT: st_q <= S_RD2;
				S_RD2: begin
					full_nx = 1'b1;
					out_data <= '{so_rd[11:0],
						(rd_idx_q + LW'(1) < len_q) ? lc_rd[11:0] : 12'd0, salcp_pkg::ST_OK};
					st_q <= S_IDLE;
				end
				S_HCLR: begin
					if (i_q == LW'(257)) begin i_q <= '0; ph_q <= '0; st_q <= S_HCNT; end
					else i_q <= i_q + LW'(1);
				end
				S_HCNT, S_HPLACE, S_BCNT, S_BPLACE: begin
					// read source, read bucket, write bucket (+ target)
					if (ph_q == 3'd3) begin
						ph_q <= '0;
						if (i_q + LW'(1) == m_q) begin
							i_q <= '0;
							unique case (st_q)
								S_HCNT: st_q <= S_HPFX;
								S_HPLACE: begin st_q <= S_HRANK; r_q <= '0; end
								S_BCNT: st_q <= S_BPFX;
								default: begin st_q <= S_NCLS; r_q <= '0; end
							endcase
							a_q <= '0;
						end else i_q <= i_q + LW'(1);
					end else ph_q <= ph_q + 3'd1;
				end
				S_HPFX, S_BPFX: begin
					// running sum: read i, write i with acc
					if (ph_q == 3'd1) begin
						ph_q <= '0;
						a_q <= a_q + bk_rd;
						if ((st_q == S_HPFX && i_q == LW'(257)) ||
							(st_q == S_BPFX && i_q == m_q)) begin
							i_q <= '0;
							st_q <= (st_q == S_HPFX) ? S_HPLACE : S_BPLACE;
						end else i_q <= i_q + LW'(1);
					end else ph_q <= ph_q + 3'd1;
				end
				S_HRANK: begin
					// phases: read so[r]; read text[b]; write class
					if (ph_q == 3'd2) begin
						ph_q <= '0;
						c_q <= t_rd;
						a_q <= b_q;
						if (r_q + LW'(1) == m_q) begin
							h_q <= LW'(1);
							i_q <= '0;
							st_q <= (m_q > LW'(1)) ? S_SHIFT : S_INV;
							r_q <= '0;
						end else r_q <= r_q + LW'(1);
					end else begin
						if (ph_q == 3'd1) b_q <= so_rd;
						ph_q <= ph_q + 3'd1;
					end
				end
				S_SHIFT: begin
					if (ph_q == 3'd1) begin
						ph_q <= '0;
						if (i_q + LW'(1) == m_q) begin i_q <= '0; st_q <= S_BCLR; end
						else i_q <= i_q + LW'(1);
					end else ph_q <= ph_q + 3'd1;
				end
				S_BCLR: begin
					if (i_q == m_q) begin i_q <= '0; ph_q <= '0; st_q <= S_BCNT; end
					else i_q <= i_q + LW'(1);
				end
				S_NCLS: begin
					// per r: read so[r]; read cr[b]; read cr[(b+h)%m]; write
					if (ph_q == 3'd3) begin
						ph_q <= '0;
						a_q <= b_q; x_q <= j_q; kh_q <= cr_rd;
						if (r_q + LW'(1) == m_q) begin r_q <= '0; st_q <= S_CPY; end
						else r_q <= r_q + LW'(1);
					end else begin
						if (ph_q == 3'd1) b_q <= so_rd;
						if (ph_q == 3'd2) j_q <= cr_rd;
						ph_q <= ph_q + 3'd1;
					end
				end
				S_CPY: begin
					if (ph_q == 3'd1) begin
						ph_q <= '0;
						if (r_q + LW'(1) == m_q) begin
							r_q <= '0;
							if ((h_q << 1) < m_q) begin h_q <= h_q << 1; st_q <= S_SHIFT; end
							else st_q <= S_INV;
						end else r_q <= r_q + LW'(1);
					end else ph_q <= ph_q + 3'd1;
				end
				S_INV: begin
					if (ph_q == 3'd1) begin
						ph_q <= '0;
						if (r_q + LW'(1) == m_q) begin
							i_q <= '0; kh_q <= '0; st_q <= S_KAS;
						end else r_q <= r_q + LW'(1);
					end else ph_q <= ph_q + 3'd1;
				end
				S_KAS: begin
					// 0: read cr[i]; 1: tr; read so[tr+2]; 3: j; 4-5: read texts; 6: compare; 7: write lcp
					unique case (ph_q)
						3'd0: ph_q <= 3'd1;
						3'd1: begin
							tr_q <= cr_rd - LW'(1);
							if (cr_rd >= len_q) begin
								kh_q <= '0;
								ph_q <= 3'd0;
								if (i_q + LW'(1) >= len_q) begin built_q <= 1'b1; st_q <= S_IDLE; end
								else i_q <= i_q + LW'(1);
							end else ph_q <= 3'd2;
						end
						3'd2: ph_q <= 3'd3;
						3'd3: begin j_q <= so_rd; ph_q <= 3'd4; end
						3'd4: begin
							if (i_q + kh_q < len_q && j_q + kh_q < len_q) ph_q <= 3'd5;
							else ph_q <= 3'd7;
						end
						3'd5: ph_q <= 3'd6; // texts read in flight
						3'd6: begin
							if (c_q == t_rd) begin kh_q <= kh_q + LW'(1); ph_q <= 3'd4; end
							else ph_q <= 3'd7;
						end
						default: begin
							// lcp written this phase
							kh_q <= (kh_q != '0) ? kh_q - LW'(1) : '0;
							ph_q <= 3'd0;
							if (i_q + LW'(1) >= len_q) begin built_q <= 1'b1; st_q <= S_IDLE; end
							else i_q <= i_q + LW'(1);
						end
					endcase
				end
				S_APP: st_q <= S_IDLE;
				default: st_q <= S_IDLE;
			endcase
			out_full <= full_nx;
			// capture helper values sampled in the bucket, ranking, class and Kasai loops
			if ((st_q == S_HCNT || st_q == S_HPLACE) && ph_q == 3'd1) x_q <= sym(i_q, len_q, t_rd);
			if ((st_q == S_BCNT) && ph_q == 3'd1) x_q <= cr_rd;
			if (st_q == S_BPLACE && ph_q == 3'd1) begin b_q <= sh_rd; end
			if (st_q == S_BPLACE && ph_q == 3'd2) x_q <= cr_rd;
			if (st_q == S_HRANK && ph_q == 3'd1) w_q <= (r_q == '0) ? '0 : v_q;
			if (st_q == S_HRANK && ph_q == 3'd2)
				w_q <= (r_q == '0) ? '0 :
					v_q + ((sym(a_q, len_q, c_q) != sym(b_q, len_q, t_rd)) ? LW'(1) : LW'(0));
			if (st_q == S_HRANK && ph_q == 3'd2) v_q <= (r_q == '0) ? '0 :
				v_q + ((sym(a_q, len_q, c_q) != sym(b_q, len_q, t_rd)) ? LW'(1) : LW'(0));
			if (st_q == S_NCLS && ph_q == 3'd3) begin
				if (r_q == '0) v_q <= '0;
				else v_q <= v_q + ((x_q != j_q || kh_q != cr_rd) ? LW'(1) : LW'(0));
			end
			if (st_q == S_KAS && ph_q == 3'd5) c_q <= t_rd;
		end
	end

	// RAM port control
	always_comb begin
		t_we = 1'b0; t_wa = len_q[TAW-1:0]; t_wd = in_data.char_value; t_ra = '0;
		so_we = 1'b0; so_wa = '0; so_wd = '0; so_ra = '0;
		cr_we = 1'b0; cr_wa = '0; cr_wd = '0; cr_ra = '0;
		sh_we = 1'b0; sh_wa = '0; sh_wd = '0; sh_ra = '0;
		bk_we = 1'b0; bk_wa = '0; bk_wd = '0; bk_ra = '0;
		lc_we = 1'b0; lc_wa = tr_q[TAW-1:0]; lc_wd = kh_q; lc_ra = '0;
		sa_tmp = '0;
		unique case (st_q)
			S_IDLE: begin
				if (in_acc && in_data.operation == salcp_pkg::OP_APPEND) begin
					t_wa = built_q ? '0 : len_q[TAW-1:0];
					t_we = built_q || (len_q < LW'(MAX_LEN));
				end
				so_ra = SAW'(in_data.rank_index) + SAW'(1);
				lc_ra = TAW'(in_data.rank_index);
			end
			S_RDWAIT, S_RD2: begin
				so_ra = SAW'(rd_idx_q + LW'(1));
				lc_ra = rd_idx_q[TAW-1:0];
			end
			S_HCLR, S_BCLR: begin
				bk_we = 1'b1; bk_wa = BAW'(i_q); bk_wd = '0;
			end
			S_HCNT, S_HPLACE: begin
				t_ra = i_q[TAW-1:0];
				bk_ra = (st_q == S_HCNT) ? BAW'(x_q + LW'(1)) : BAW'(x_q);
				if (ph_q == 3'd3) begin
					bk_we = 1'b1;
					bk_wa = bk_ra;
					bk_wd = bk_rd + LW'(1);
					if (st_q == S_HPLACE) begin
						so_we = 1'b1; so_wa = SAW'(bk_rd); so_wd = i_q;
					end
				end
			end
			S_HPFX, S_BPFX: begin
				bk_ra = BAW'(i_q);
				if (ph_q == 3'd1) begin
					bk_we = 1'b1; bk_wa = BAW'(i_q); bk_wd = a_q + bk_rd;
				end
			end
			S_HRANK: begin
				so_ra = SAW'(r_q);
				t_ra = b_q[TAW-1:0];
				if (ph_q == 3'd2) begin
					cr_we = 1'b1; cr_wa = SAW'(b_q); cr_wd = w_q;
					if (r_q != '0)
						cr_wd = v_q + ((sym(a_q, len_q, c_q) != sym(b_q, len_q, t_rd))
							? LW'(1) : LW'(0));
					else cr_wd = '0;
				end
				if (ph_q == 3'd1) t_ra = so_rd[TAW-1:0];
			end
			S_SHIFT: begin
				so_ra = SAW'(i_q);
				if (ph_q == 3'd1) begin
					sa_tmp = so_rd + m_q - h_q;
					sh_we = 1'b1; sh_wa = SAW'(i_q);
					sh_wd = (sa_tmp >= m_q) ? sa_tmp - m_q : sa_tmp;
				end
			end
			S_BCNT: begin
				cr_ra = SAW'(i_q);
				bk_ra = BAW'(x_q + LW'(1));
				if (ph_q == 3'd3) begin
					bk_we = 1'b1; bk_wa = bk_ra; bk_wd = bk_rd + LW'(1);
				end
			end
			S_BPLACE: begin
				sh_ra = SAW'(i_q);
				cr_ra = SAW'(b_q);
				if (ph_q == 3'd1) cr_ra = SAW'(sh_rd);
				bk_ra = BAW'(x_q);
				if (ph_q == 3'd2) bk_ra = BAW'(cr_rd);
				if (ph_q == 3'd3) begin
					bk_we = 1'b1; bk_wa = bk_ra; bk_wd = bk_rd + LW'(1);
					so_we = 1'b1; so_wa = SAW'(bk_rd); so_wd = b_q;
				end
			end
			S_NCLS: begin
				so_ra = SAW'(r_q);
				cr_ra = SAW'(b_q);
				if (ph_q == 3'd1) cr_ra = SAW'(so_rd);
				if (ph_q == 3'd2) cr_ra = SAW'(addm(b_q, h_q, m_q));
				if (ph_q == 3'd3) begin
					sh_we = 1'b1; sh_wa = SAW'(r_q);
					sh_wd = (r_q == '0) ? '0 :
						v_q + ((x_q != j_q || kh_q != cr_rd) ? LW'(1) : LW'(0));
				end
			end
			S_CPY: begin
				so_ra = SAW'(r_q);
				sh_ra = SAW'(r_q);
				if (ph_q == 3'd1) begin
					cr_we = 1'b1; cr_wa = SAW'(so_rd); cr_wd = sh_rd;
				end
			end
			S_INV: begin
				so_ra = SAW'(r_q);
				if (ph_q == 3'd1) begin
					cr_we = 1'b1; cr_wa = SAW'(so_rd); cr_wd = r_q;
				end
			end
			S_KAS: begin
				cr_ra = SAW'(i_q);
				so_ra = SAW'(tr_q + LW'(2));
				t_ra = (ph_q == 3'd4) ? TAW'(i_q + kh_q) : TAW'(j_q + kh_q);
				if (ph_q == 3'd7) lc_we = 1'b1;
			end
			default: ;
		endcase
	end

	`SA_ASSERT_IMP(a_build_no_accept, clk, arst_n, st_q != S_IDLE, in_stall,
		"item accepted during build")
	`SA_ASSERT_NXT(a_len_bound, clk, arst_n, 1'b1, len_q <= LW'(MAX_LEN),
		"text length beyond capacity")
	`SA_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid,
		"result beat dropped while stalled")
endmodule

// ----- sim/suffix_array_lcp_builder_tb.sv -----
// Self-checking testbench for suffix_array_lcp_builder: text loads, builds, ranked reads.
// Depends on salcp_pkg and the block's RTL; expected beats come from an in-bench predictor.
`timescale 1ns / 100ps
module suffix_array_lcp_builder_tb;

	localparam int TEXT_MAX = salcp_pkg::MAX_LEN_DEF;
	localparam int IDLE_LIMIT = 5000000;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	salcp_pkg::in_item_t  in_data;
	logic                 out_valid;
	logic                 out_stall;
	salcp_pkg::out_item_t out_data;

	suffix_array_lcp_builder dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

	// predictor state
	logic [7:0] txt_mem [TEXT_MAX];
	int         txt_len;
	bit         sa_built;
	int         sa_ord [TEXT_MAX + 1];
	int         cls [TEXT_MAX + 1];
	int         tmp_ord [TEXT_MAX + 1];
	int         bkt [TEXT_MAX + 2];
	int         lcp_tab [TEXT_MAX];
	int         sym_cnt [258];

	salcp_pkg::out_item_t expected_beats [$];
	int         mismatches;
	bit         quiet;
	bit         pressure_req;
	int         idle_cycles;

	// clock: 12 ns period
	always begin
		clk = 1'b1; #6;
		clk = 1'b0; #6;
	end

	function automatic int sym_at(int i, int n);
		return (i >= n) ? 0 : int'(txt_mem[i]) + 1;
	endfunction

	// order all suffixes by prefix doubling, then Kasai LCP
	function automatic void build_suffix_order();
		int n, m, i, r, h, a, b, x, tr, j;
		bit diff;
		n = txt_len;
		m = n + 1;
		for (i = 0; i < 258; i++) sym_cnt[i] = 0;
		for (i = 0; i < m; i++) sym_cnt[sym_at(i, n) + 1]++;
		for (i = 1; i < 258; i++) sym_cnt[i] += sym_cnt[i - 1];
		for (i = 0; i < m; i++) begin
			sa_ord[sym_cnt[sym_at(i, n)]] = i;
			sym_cnt[sym_at(i, n)]++;
		end
		cls[sa_ord[0]] = 0;
		for (r = 1; r < m; r++) begin
			a = sa_ord[r - 1]; b = sa_ord[r];
			cls[b] = cls[a] + ((sym_at(a, n) != sym_at(b, n)) ? 1 : 0);
		end
		for (h = 1; h < m; h = h << 1) begin
			for (i = 0; i < m; i++) tmp_ord[i] = (sa_ord[i] + m - h) % m;
			for (i = 0; i <= m; i++) bkt[i] = 0;
			for (i = 0; i < m; i++) bkt[cls[i] + 1]++;
			for (i = 1; i <= m; i++) bkt[i] += bkt[i - 1];
			for (i = 0; i < m; i++) begin
				x = tmp_ord[i];
				sa_ord[bkt[cls[x]]] = x;
				bkt[cls[x]]++;
			end
			tmp_ord[0] = 0;
			for (r = 1; r < m; r++) begin
				a = sa_ord[r - 1]; b = sa_ord[r];
				diff = (cls[a] != cls[b]) || (cls[(a + h) % m] != cls[(b + h) % m]);
				tmp_ord[r] = tmp_ord[r - 1] + (diff ? 1 : 0);
			end
			for (r = 0; r < m; r++) cls[sa_ord[r]] = tmp_ord[r];
		end
		for (r = 0; r < m; r++) cls[sa_ord[r]] = r;
		h = 0;
		for (i = 0; i < n; i++) begin
			tr = cls[i] - 1;
			if (tr + 1 >= n) begin
				h = 0;
				continue;
			end
			j = sa_ord[tr + 2];
			while (i + h < n && j + h < n && txt_mem[i + h] == txt_mem[j + h]) h++;
			lcp_tab[tr] = h;
			if (h > 0) h--;
		end
		sa_built = 1'b1;
	endfunction

	// update predictor for one accepted beat, queue its result if any
	function automatic void predict_beat(salcp_pkg::in_item_t it);
		salcp_pkg::out_item_t res;
		int idx;
		res = '0;
		if (it.operation == salcp_pkg::OP_APPEND) begin
			if (sa_built) begin
				sa_built = 1'b0;
				txt_len = 0;
			end
			if (txt_len < TEXT_MAX) begin
				txt_mem[txt_len] = it.char_value;
				txt_len++;
				if (it.end_of_text) build_suffix_order();
			end else begin
				if (it.end_of_text) build_suffix_order();
				res.status = salcp_pkg::ST_OVERFLOW;
				expected_beats.push_back(res);
			end
		end else begin
			idx = int'(it.rank_index);
			if (!sa_built || idx >= txt_len) begin
				res.status = salcp_pkg::ST_BAD_INDEX;
			end else begin
				res.suffix_start = sa_ord[idx + 1][11:0];
				res.lcp_with_next = (idx + 1 < txt_len) ? lcp_tab[idx][11:0] : 12'd0;
				res.status = salcp_pkg::ST_OK;
			end
			expected_beats.push_back(res);
		end
	endfunction

	// drive one beat, with an optional idle burst ahead of it
	task automatic send_item(salcp_pkg::in_item_t it);
		int gap;
		if (!quiet && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 6);
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end else begin
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (in_stall);
		predict_beat(it);
	endtask

	task automatic send_append(logic [7:0] ch, logic last);
		salcp_pkg::in_item_t it;
		it = '0;
		it.operation = salcp_pkg::OP_APPEND;
		it.char_value = ch;
		it.end_of_text = last;
		it.rank_index = 12'($urandom);
		send_item(it);
	endtask

	task automatic send_read(logic [11:0] idx, logic last);
		salcp_pkg::in_item_t it;
		it = '0;
		it.operation = salcp_pkg::OP_READ;
		it.char_value = 8'($urandom);
		it.end_of_text = last;
		it.rank_index = idx;
		send_item(it);
	endtask

	// load a text of len bytes drawn from [lo, hi]
	task automatic load_text(int len, int lo, int hi);
		int i;
		for (i = 0; i < len; i++)
			send_append(8'($urandom_range(lo, hi)), i == len - 1);
	endtask

	// read every rank of the current text
	task automatic read_all_ranks();
		int i, n;
		n = txt_len;
		for (i = 0; i < n; i++) send_read(12'(i), 1'b0);
	endtask

	task automatic test_read_before_build();
		send_read(12'd0, 1'b0);
		send_read(12'hFFF, 1'b1);
		send_append(8'h41, 1'b0);
		send_read(12'd0, 1'b0);
	endtask

	task automatic test_directed_texts();
		send_append(8'h00, 1'b1);
		send_read(12'd0, 1'b0);
		send_read(12'd1, 1'b0);
		send_append(8'hFF, 1'b0);
		send_append(8'h00, 1'b0);
		send_append(8'hFF, 1'b1);
		read_all_ranks();
		send_read(12'd1, 1'b1);
		send_read(12'hFFF, 1'b0);
		load_text(8, 8'h61, 8'h61);
		read_all_ranks();
	endtask

	// fill to capacity, then push two more bytes, the second closing the text
	task automatic test_overflow();
		int i;
		for (i = 0; i < TEXT_MAX - 1; i++) send_append(8'($urandom_range(0, 1)), 1'b0);
		send_append(8'h01, 1'b0);
		send_append(8'h07, 1'b0);
		send_append(8'hFE, 1'b1);
		send_read(12'd0, 1'b0);
		send_read(12'hFFF, 1'b0);
		repeat (20) send_read(12'($urandom), 1'b0);
	endtask

	// long receiver hold-off while reads keep coming
	task automatic test_backpressure();
		int i;
		load_text(30, 0, 3);
		pressure_req = 1'b1;
		for (i = 0; i < 100; i++) send_read(12'($urandom_range(0, 29)), 1'b0);
	endtask

	task automatic test_random(int items);
		int sent, len, lo, hi, i, k;
		sent = 0;
		while (sent < items) begin
			if (sent > items * 85 / 100) quiet = 1'b1;
			len = $urandom_range(1, 40);
			if ($urandom_range(0, 2) == 0) begin
				lo = $urandom_range(0, 255); hi = lo + $urandom_range(0, 2);
				if (hi > 255) hi = 255;
			end else begin
				lo = 0; hi = 255;
			end
			for (i = 0; i < len; i++) begin
				send_append(8'($urandom_range(lo, hi)), i == len - 1);
				if (i != len - 1 && $urandom_range(0, 30) == 0) send_read(12'($urandom), 1'b0);
			end
			k = $urandom_range(len / 2, len + 4);
			for (i = 0; i < k; i++) begin
				case ($urandom_range(0, 9))
					0: send_read(12'($urandom), 1'($urandom));
					1: send_read(12'(len + $urandom_range(0, 3)), 1'b0);
					default: send_read(12'($urandom_range(0, len - 1)), 1'($urandom));
				endcase
			end
			sent += len + k;
		end
	endtask

	// receiver stall bursts and the requested long hold-off
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (pressure_req) begin
				out_stall <= 1'b1;
				repeat (300) @(negedge clk);
				pressure_req = 1'b0;
				out_stall <= 1'b0;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 6)) @(negedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// compare each result beat with the oldest expectation
	always @(posedge clk) begin
		salcp_pkg::out_item_t exp_beat;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_beats.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result beat: %p", out_data);
			end else begin
				exp_beat = expected_beats.pop_front();
				if (out_data.suffix_start !== exp_beat.suffix_start ||
				    out_data.lcp_with_next !== exp_beat.lcp_with_next ||
				    out_data.status !== exp_beat.status) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch at %0t: expected %0d/%0d/%0d, got %0d/%0d/%0d",
							$realtime, exp_beat.suffix_start, exp_beat.lcp_with_next,
							exp_beat.status, out_data.suffix_start,
							out_data.lcp_with_next, out_data.status);
				end
			end
		end
	end

	// end the run if nothing moves for too long
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		txt_len = 0;
		sa_built = 1'b0;
		mismatches = 0;
		quiet = 1'b0;
		pressure_req = 1'b0;
		idle_cycles = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_read_before_build();
		test_directed_texts();
		test_overflow();
		test_backpressure();
		test_random(2000);

		@(negedge clk);
		in_valid <= 1'b0;
		wait (expected_beats.size() == 0);
		repeat (20) @(posedge clk);
		if (mismatches == 0 && expected_beats.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end
endmodule
